### rtl/crng_pkg.sv
// Package for the combined LCG shuffle generator: word widths, generator constants,
// request and result word types, and the sequencer state type.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package crng_pkg;

	localparam int unsigned WORD_W = 31;
	localparam int unsigned UNIT_W = 32;
	localparam int unsigned CMUL_W = 16;
	localparam int unsigned PROD_W = WORD_W + CMUL_W;
	localparam int unsigned OFF_W = 8;

	localparam logic [WORD_W-1:0] MOD_ONE = 31'd2147483563;
	localparam logic [WORD_W-1:0] MOD_TWO = 31'd2147483399;
	localparam logic [WORD_W-1:0] TOP_DRAW = 31'd2147483562;

	localparam logic [CMUL_W-1:0] MUL_ONE = 16'd40014;
	localparam logic [CMUL_W-1:0] MUL_TWO = 16'd40692;

	// Each modulus is 2^31 minus a small offset, so 2^31 folds back as that offset.
	localparam logic [OFF_W-1:0] OFF_ONE = 8'd85;
	localparam logic [OFF_W-1:0] OFF_TWO = 8'd249;

	// 2^32 / MOD_ONE equals 2 + 170 / MOD_ONE, which gives the fraction without a divider.
	localparam logic [OFF_W-1:0] UNIT_MUL = 8'd170;
	localparam logic [UNIT_W-1:0] UNIT_CLAMP = 32'd4294966780;

	localparam logic [WORD_W-1:0] GEN_ONE_RST = 31'd1;
	localparam logic [WORD_W-1:0] GEN_TWO_RST = 31'd123456789;

	localparam int unsigned WARMUP = 8;
	localparam int unsigned TABLE_SIZE_DEF = 32;

	typedef struct packed {
		logic req_type;
		logic [WORD_W-1:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] draw;
		logic [UNIT_W-1:0] unit_value;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_RED,
		ST_DRAW_MUL,
		ST_DRAW_RED,
		ST_UNIT_MUL,
		ST_UNIT_RED
	} state_t;

endpackage

`default_nettype wire

### rtl/crng_gens.sv
// Step unit for both congruential generators: a registered constant product,
// then a fold of the high bits and one conditional subtract. Depends on crng_pkg.
`default_nettype none

module crng_gens import crng_pkg::*; (
	input  logic              clk,
	input  logic [WORD_W-1:0] gen_one,
	input  logic [WORD_W-1:0] gen_two,
	output logic [WORD_W-1:0] next_one,
	output logic [WORD_W-1:0] next_two
);

	logic [PROD_W-1:0] prod_one_s1;
	logic [PROD_W-1:0] prod_two_s1;

	function automatic logic [WORD_W-1:0] fold(
		input logic [PROD_W-1:0] p,
		input logic [OFF_W-1:0]  off,
		input logic [WORD_W-1:0] m
	);
		logic [CMUL_W+OFF_W-1:0] hi_off;
		logic [WORD_W:0]         v;
		hi_off = {{OFF_W{1'b0}}, p[PROD_W-1:WORD_W]} * {{CMUL_W{1'b0}}, off};
		v = {1'b0, p[WORD_W-1:0]} + (WORD_W+1)'(hi_off);
		if (v >= {1'b0, m}) begin
			v = v - {1'b0, m};
		end
		return v[WORD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		prod_one_s1 <= PROD_W'(gen_one) * PROD_W'(MUL_ONE);
		prod_two_s1 <= PROD_W'(gen_two) * PROD_W'(MUL_TWO);
	end

	assign next_one = fold(prod_one_s1, OFF_ONE, MOD_ONE);
	assign next_two = fold(prod_two_s1, OFF_TWO, MOD_TWO);

endmodule

`default_nettype wire

### rtl/crng_unit.sv
// Converts a draw to an unsigned Q0.32 fraction of the first modulus, clamped
// below one. Registered constant product, then fold and correct. Depends on crng_pkg.
`default_nettype none

module crng_unit import crng_pkg::*; (
	input  logic              clk,
	input  logic [WORD_W-1:0] draw,
	output rsp_t              res
);

	logic [WORD_W-1:0]       draw_s1;
	logic [WORD_W+OFF_W-1:0] prod_s1;
	logic [OFF_W-1:0]        quo_hi;
	logic [2*OFF_W-1:0]      hi_off;
	logic [WORD_W:0]         rem;
	logic [OFF_W:0]          quo;
	logic [UNIT_W:0]         unit_full;

	always_ff @(posedge clk) begin
		draw_s1 <= draw;
		prod_s1 <= (WORD_W+OFF_W)'(draw) * (WORD_W+OFF_W)'(UNIT_MUL);
	end

	always_comb begin
		quo_hi = prod_s1[WORD_W+OFF_W-1:WORD_W];
		hi_off = {{OFF_W{1'b0}}, quo_hi} * {{OFF_W{1'b0}}, OFF_ONE};
		rem = {1'b0, prod_s1[WORD_W-1:0]} + (WORD_W+1)'(hi_off);
		quo = {1'b0, quo_hi} + (OFF_W+1)'(rem >= {1'b0, MOD_ONE});
		unit_full = {1'b0, draw_s1, 1'b0} + (UNIT_W+1)'(quo);
		res.draw = draw_s1;
		res.unit_value = (unit_full > {1'b0, UNIT_CLAMP}) ? UNIT_CLAMP
			: unit_full[UNIT_W-1:0];
	end

endmodule

`default_nettype wire

### rtl/crng_table.sv
// Shuffle table: synchronous memory with one write and one registered read port.
// Per-entry valid bits make an unwritten entry read as zero. Depends on crng_pkg.
`default_nettype none

module crng_table import crng_pkg::*; #(
	parameter int unsigned DEPTH = TABLE_SIZE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WORD_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_W-1:0]        wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [DEPTH-1:0]  valid_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### rtl/combined_lcg_shuffle_rng.sv
// Combined LCG generator with a shuffle table; uses crng_pkg, crng_gens, crng_unit, crng_table.
// A draw runs the generator step, then the fraction unit, in series; busy stays high until
// done, so no new request is taken mid-draw. A reseed seeds both generators, steps the first
// through a warm-up and then to fill every table entry, then runs a draw. Done is high
// for one cycle with the result, held in res until the next draw; the receiver cannot stall it.
// Reset loads the generators, clears the last output and marks every table entry empty.
`default_nettype none

module combined_lcg_shuffle_rng import crng_pkg::*; #(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t res
);

	localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
	localparam int unsigned STEPS = TABLE_SIZE + WARMUP;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);
	localparam logic [WORD_W-1:0] SLOT_DIV = WORD_W'(1 + TOP_DRAW / TABLE_SIZE);

	state_t            state_q;
	state_t            state_d;
	logic [WORD_W-1:0] gen_one_q;
	logic [WORD_W-1:0] gen_two_q;
	logic [WORD_W-1:0] last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  step_idx;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] slot_idx;
	logic              done_q;
	rsp_t              res_q;

	logic [WORD_W-1:0] next_one;
	logic [WORD_W-1:0] next_two;
	logic [WORD_W-1:0] seed_word;
	logic [WORD_W:0]   diff;
	logic [WORD_W-1:0] new_last;
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	rsp_t              unit_res;

	crng_gens u_gens (
		.clk      (clk),
		.gen_one  (gen_one_q),
		.gen_two  (gen_two_q),
		.next_one (next_one),
		.next_two (next_two)
	);

	crng_table #(
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (slot_idx),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (next_one)
	);

	crng_unit u_unit (
		.clk  (clk),
		.draw (last_q),
		.res  (unit_res)
	);

	assign seed_word = (req.seed_value == '0) ? GEN_ONE_RST : req.seed_value;
	assign step_idx = cnt_q - CNT_W'(1);

	always_comb begin
		slot_idx = '0;
		for (int k = 1; k < TABLE_SIZE; k++) begin
			if ({1'b0, last_q} >= (WORD_W+1)'(k) * (WORD_W+1)'(SLOT_DIV)) begin
				slot_idx = SLOT_W'(k);
			end
		end
	end

	always_comb begin
		diff = {1'b0, rd_data} - {1'b0, next_two};
		if (diff[WORD_W] || diff == '0) begin
			new_last = WORD_W'(diff + {1'b0, TOP_DRAW});
		end else begin
			new_last = diff[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		rd_en = 1'b0;
		wr_en = 1'b0;
		wr_addr = slot_q;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = req.req_type ? ST_SEED_MUL : ST_DRAW_MUL;
				end
			end
			ST_SEED_MUL: begin
				state_d = ST_SEED_RED;
			end
			ST_SEED_RED: begin
				if (step_idx < CNT_W'(TABLE_SIZE)) begin
					wr_en = 1'b1;
					wr_addr = step_idx[SLOT_W-1:0];
				end
				state_d = (step_idx == '0) ? ST_DRAW_MUL : ST_SEED_MUL;
			end
			ST_DRAW_MUL: begin
				rd_en = 1'b1;
				state_d = ST_DRAW_RED;
			end
			ST_DRAW_RED: begin
				wr_en = 1'b1;
				state_d = ST_UNIT_MUL;
			end
			ST_UNIT_MUL: begin
				state_d = ST_UNIT_RED;
			end
			ST_UNIT_RED: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_one_q <= GEN_ONE_RST;
			gen_two_q <= GEN_TWO_RST;
			last_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UNIT_RED);
			case (state_q)
				ST_IDLE: begin
					if (start && req.req_type) begin
						gen_one_q <= seed_word;
						gen_two_q <= seed_word;
						cnt_q <= CNT_W'(STEPS);
					end
				end
				ST_SEED_RED: begin
					gen_one_q <= next_one;
					cnt_q <= step_idx;
					if (step_idx == '0) begin
						last_q <= next_one;
					end
				end
				ST_DRAW_RED: begin
					gen_one_q <= next_one;
					gen_two_q <= next_two;
					last_q <= new_last;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW_MUL) begin
			slot_q <= slot_idx;
		end
		if (state_q == ST_UNIT_RED) begin
			res_q <= unit_res;
		end
	end

	assign done = done_q;
	assign res = res_q;

	a_done_after_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_UNIT_RED)
		else $error("done without a finished conversion");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_seed_path: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type) |=> state_q == ST_SEED_MUL && cnt_q == CNT_W'(STEPS))
		else $error("reseed request did not start the warmup");

	a_draw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.draw != '0 && res.draw <= TOP_DRAW && res.unit_value <= UNIT_CLAMP)
		else $error("result word out of range");

endmodule

`default_nettype wire
